// ===== sv/deq_pkg.sv =====
// ============================================================================
// deq_pkg - shared types and constants for the dynamic EQ band
// Widths, fixed-point constants, register indexes, register bank type.
// ============================================================================
package deq_pkg;

    localparam int SampleBitsDefault  = 24;
    localparam int GainAttackDefault  = 65341;
    localparam int GainReleaseDefault = 65525;

    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 24;

    localparam logic [CfgIdxBits-1:0] REG_BP_B0     = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_BP_A1     = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_BP_A2     = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_ENV_ATK   = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_ENV_REL   = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_THRESHOLD = 3'd5;
    localparam logic [CfgIdxBits-1:0] REG_SLOPE     = 3'd6;
    localparam logic [CfgIdxBits-1:0] REG_DEPTH     = 3'd7;

    localparam logic signed [15:0] DbFloor     = -16'sd25600;
    localparam logic        [14:0] DbPerLog2   = 15'd24660;
    localparam logic        [13:0] Log2TenBy20 = 14'd10885;

    // Horner coefficients of 2^(-f)
    localparam logic [16:0] Horner0 = 17'd630;
    localparam logic [16:0] Horner1 = 17'd3638;
    localparam logic [16:0] Horner2 = 17'd15744;
    localparam logic [16:0] Horner3 = 17'd45426;
    localparam logic [16:0] Horner4 = 17'd65536;

    // configuration register bank
    typedef struct packed {
        logic signed [23:0] bp_b0;
        logic signed [23:0] bp_a1;
        logic signed [23:0] bp_a2;
        logic        [15:0] env_attack;
        logic        [15:0] env_release;
        logic signed [15:0] threshold_db;
        logic        [14:0] slope_scaled;
        logic        [13:0] depth_scaled;
    } t_cfg;

endpackage

// ===== sv/dynamic_eq_band.sv =====
// ============================================================================
// dynamic_eq_band - one band of a dynamic equalizer
// Band-pass detector, envelope, dB level, compression gain and band removal,
// all sequenced over one shared multiplier.
// ============================================================================
//  channel   dir  tdata bits (low first)              tuser/tlast
//  s_axis    in   sample_in[SB-1:0]                    -
//  m_axis    out  sample_out[SB-1:0], reduction_db[13:0] -
//  cfg       in   index 0..7, data 24 bit              -
//
// Each sequencer step is an operand state and a product state on the shared
// multiplier; ten steps form the log2 fraction and four the exponent, plus
// one mantissa setup state. The block takes no item while one is at work or
// its result is unread, so it cannot take a new item before it is through
// with the last; a stalled result holds the input off.
// Reset (synchronous, active low) clears filter, envelope, reduction and
// restores the register defaults.
// ============================================================================
module dynamic_eq_band #(
    parameter int SAMPLE_BITS       = deq_pkg::SampleBitsDefault,
    parameter int GAIN_ATTACK_COEF  = deq_pkg::GainAttackDefault,
    parameter int GAIN_RELEASE_COEF = deq_pkg::GainReleaseDefault,
    localparam int OutBits = ((SAMPLE_BITS + 14 + 7) / 8) * 8,
    localparam int InBits  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [InBits-1:0]                s_axis_tdata,  // sample_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [OutBits-1:0]               m_axis_tdata,  // sample_out, reduction_db
    input  logic                             i_cfg_we,
    input  logic [deq_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [deq_pkg::CfgDataBits-1:0]  i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam logic signed [63:0] SMax = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam logic signed [63:0] SMin = -SMax - 64'sd1;
    localparam logic signed [63:0] S48Max = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48Min = -S48Max - 64'sd1;
    localparam logic [16:0] GAtk = 17'(GAIN_ATTACK_COEF);
    localparam logic [16:0] GRel = 17'(GAIN_RELEASE_COEF);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ACC, ST_ACC_W, ST_S1, ST_S1_W, ST_S2A, ST_S2A_W, ST_S2B, ST_S2B_W,
        ST_ENV, ST_ENV_W, ST_MANT, ST_LOG, ST_LOG_W, ST_DB, ST_DB_W, ST_CMP, ST_CMP_W,
        ST_GR, ST_GR_W, ST_EXP, ST_EXP_W, ST_REM, ST_REM_W, ST_OUT, ST_OUT_W
    } t_state;

    t_state               r_state;
    deq_pkg::t_cfg        r_cfg;
    logic signed [47:0]   r_s1, r_s2;
    logic [SB-2:0]        r_env;
    logic [15:0]          r_gr;
    logic signed [SB-1:0] r_x, r_y;
    logic signed [63:0]   r_t;      // scratch
    logic [16:0]          r_m;      // log mantissa
    logic [9:0]           r_frac;
    logic [3:0]           r_cnt;
    logic [5:0]           r_p;
    logic [16:0]          r_f, r_hp;
    logic [4:0]           r_n;
    logic                 r_ovld;
    logic [SB-1:0]        r_out;

    logic signed [33:0] w_a, w_b;
    logic signed [67:0] w_p;

    deq_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    function automatic logic signed [63:0] sat64(input logic signed [67:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        if (v < 68'(lo)) return lo;
        if (v > 68'(hi)) return hi;
        return v[63:0];
    endfunction

    logic signed [63:0] w_d;   // |y| limited
    logic [5:0]         w_top;
    logic signed [67:0] w_rnd;
    logic [15:0]        w_tgt;
    logic [16:0]        w_gc;
    logic signed [63:0] w_l;   // Q.10 log2 of the envelope
    logic signed [63:0] w_lvl, w_over;
    logic signed [67:0] w_e;   // Q.16 exponent of the reduction
    always_comb begin
        w_d = (r_y < 0) ? -64'(r_y) : 64'(r_y);
        if (w_d > SMax) w_d = SMax;
        w_top = '0;
        for (int i = 0; i < SB - 1; i++) if (r_env[i]) w_top = 6'(i);
        w_rnd = w_p + 68'sd32768;
        w_tgt = (r_t[15:0] < {2'b0, r_cfg.depth_scaled}) ? r_t[15:0]
                                                         : {2'b0, r_cfg.depth_scaled};
        w_gc  = (w_tgt > r_gr) ? GAtk : GRel;
        w_l   = (64'(r_p) - 64'(SB - 1)) * 64'sd1024 + 64'(r_frac);
        // level from the L product, floored, then excess over threshold
        w_lvl = (r_env == '0) ? 64'(deq_pkg::DbFloor) : 64'((w_p + 68'sd8192) >>> 14);
        if (w_lvl < 64'(deq_pkg::DbFloor)) w_lvl = 64'(deq_pkg::DbFloor);
        w_over = w_lvl - 64'(r_cfg.threshold_db);
        if (w_over < 0) w_over = '0;
        w_e = (w_p + 68'sd128) >>> 8;
    end

    // select multiplier operands by step
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_ACC: begin w_a = 34'(r_cfg.bp_b0); w_b = 34'(r_x); end
            ST_S1:  begin w_a = -34'(r_cfg.bp_a1); w_b = 34'(r_y); end
            ST_S2A: begin w_a = -34'(r_cfg.bp_b0); w_b = 34'(r_x); end
            ST_S2B: begin w_a = 34'(r_cfg.bp_a2); w_b = 34'(r_y); end
            ST_ENV: begin
                w_a = {18'b0, ((w_d > 64'(r_env)) ? r_cfg.env_attack : r_cfg.env_release)};
                w_b = 34'(64'(r_env) - w_d);
            end
            ST_LOG: begin w_a = {17'b0, r_m}; w_b = {17'b0, r_m}; end
            ST_DB:  begin w_a = 34'(w_l); w_b = {19'b0, deq_pkg::DbPerLog2}; end
            ST_CMP: begin w_a = 34'(r_t); w_b = {19'b0, r_cfg.slope_scaled}; end
            ST_GR:  begin w_a = {17'b0, w_gc}; w_b = {18'b0, r_gr} - {18'b0, w_tgt}; end
            ST_EXP: begin w_a = {18'b0, r_gr}; w_b = {20'b0, deq_pkg::Log2TenBy20}; end
            ST_REM: begin w_a = {17'b0, r_hp}; w_b = {17'b0, r_f}; end
            ST_OUT: begin w_a = 34'(r_y); w_b = 34'(r_t); end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = OutBits'({r_gr[13:0], r_out});

    // sequencer, datapath registers and output holding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
            r_s1 <= '0; r_s2 <= '0; r_env <= '0; r_gr <= '0;
            r_cfg <= '{bp_b0: '0, bp_a1: '0, bp_a2: '0, env_attack: 16'd65081,
                       env_release: 16'd65520, threshold_db: -16'sd9216,
                       slope_scaled: 15'd9557, depth_scaled: 14'd768};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    deq_pkg::REG_BP_B0:     r_cfg.bp_b0 <= i_cfg_data;
                    deq_pkg::REG_BP_A1:     r_cfg.bp_a1 <= i_cfg_data;
                    deq_pkg::REG_BP_A2:     r_cfg.bp_a2 <= i_cfg_data;
                    deq_pkg::REG_ENV_ATK:   r_cfg.env_attack <= i_cfg_data[15:0];
                    deq_pkg::REG_ENV_REL:   r_cfg.env_release <= i_cfg_data[15:0];
                    deq_pkg::REG_THRESHOLD: r_cfg.threshold_db <= i_cfg_data[15:0];
                    deq_pkg::REG_SLOPE:     r_cfg.slope_scaled <= i_cfg_data[14:0];
                    deq_pkg::REG_DEPTH:     r_cfg.depth_scaled <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_x <= s_axis_tdata[SB-1:0];
                    r_state <= ST_ACC;
                end
                ST_ACC:   r_state <= ST_ACC_W;
                ST_ACC_W: begin
                    // y = sat((b0*x + s1 + 2^19) >> 20)
                    r_y <= SB'(sat64((w_p + 68'(r_s1) + 68'sd524288) >>> 20, SMin, SMax));
                    r_state <= ST_S1;
                end
                ST_S1:    r_state <= ST_S1_W;
                ST_S1_W: begin
                    r_s1 <= 48'(sat64(w_p + 68'(r_s2), S48Min, S48Max));
                    r_state <= ST_S2A;
                end
                ST_S2A:   r_state <= ST_S2A_W;
                ST_S2A_W: begin r_t <= w_p[63:0]; r_state <= ST_S2B; end
                ST_S2B:   r_state <= ST_S2B_W;
                ST_S2B_W: begin
                    r_s2 <= 48'(sat64(68'(r_t) - w_p, S48Min, S48Max));
                    r_state <= ST_ENV;
                end
                ST_ENV:   r_state <= ST_ENV_W;
                ST_ENV_W: begin
                    r_env <= (SB-1)'(w_d + 64'(w_rnd >>> 16));
                    r_state <= ST_MANT;
                    r_cnt <= '0;
                    r_frac <= '0;
                end
                ST_MANT: begin
                    // normalize the envelope so its top one lands on bit 15
                    r_m <= (w_top >= 6'd15) ? 17'(r_env >> (w_top - 6'd15))
                                            : 17'(64'(r_env) << (6'd15 - w_top));
                    r_p <= w_top;
                    r_state <= ST_LOG;
                end
                ST_LOG:   r_state <= ST_LOG_W;
                ST_LOG_W: begin
                    if (w_p[67:15] >= 53'd65536) begin
                        r_m <= 17'(w_p[67:16]);
                        r_frac <= {r_frac[8:0], 1'b1};
                    end else begin
                        r_m <= 17'(w_p[67:15]);
                        r_frac <= {r_frac[8:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    r_state <= (r_cnt == 4'd9) ? ST_DB : ST_LOG;
                end
                ST_DB: begin
                    r_state <= ST_DB_W;
                end
                ST_DB_W: begin
                    r_t <= w_over;
                    r_state <= ST_CMP;
                end
                ST_CMP:   r_state <= ST_CMP_W;
                ST_CMP_W: begin
                    r_t <= 64'((w_p + 68'sd8192) >>> 14);
                    r_state <= ST_GR;
                end
                ST_GR:    r_state <= ST_GR_W;
                ST_GR_W: begin
                    r_gr <= 16'(68'(w_tgt) + (w_rnd >>> 16));
                    r_state <= ST_EXP;
                end
                ST_EXP:   r_state <= ST_EXP_W;
                ST_EXP_W: begin
                    r_n  <= (w_e[67:16] > 52'd16) ? 5'd17 : 5'(w_e[20:16]);
                    r_f  <= {1'b0, w_e[15:0]};
                    r_hp <= deq_pkg::Horner0;
                    r_cnt <= '0;
                    r_state <= ST_REM;
                end
                ST_REM:   r_state <= ST_REM_W;
                ST_REM_W: begin
                    r_cnt <= r_cnt + 4'd1;
                    case (r_cnt)
                        4'd0: r_hp <= deq_pkg::Horner1 - 17'(w_rnd >>> 16);
                        4'd1: r_hp <= deq_pkg::Horner2 - 17'(w_rnd >>> 16);
                        4'd2: r_hp <= deq_pkg::Horner3 - 17'(w_rnd >>> 16);
                        default: r_hp <= deq_pkg::Horner4 - 17'(w_rnd >>> 16);
                    endcase
                    if (r_cnt == 4'd3) begin
                        r_t <= 64'd65536 - ((r_n > 5'd16) ? 64'd0 :
                               64'((deq_pkg::Horner4 - 17'(w_rnd >>> 16)) >> r_n));
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_REM;
                    end
                end
                ST_OUT: begin
                    r_cnt <= '0;
                    r_state <= ST_OUT_W;
                end
                ST_OUT_W: begin
                    // subtract the removed band part and present the result
                    r_out <= SB'(sat64(68'(r_x) - ((w_p + 68'sd32768) >>> 16), SMin, SMax));
                    r_ovld <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/deq_mul.sv =====
// ============================================================================
// deq_mul - shared registered multiplier
// One signed 34x34 product a cycle with the result registered.
// ============================================================================
module deq_mul (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [67:0] o_p
);

    // register the product
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top - stream testbench for the dynamic EQ band
// Drives audio items with random gaps, predicts each result with a bit-exact
// model of the band compressor and checks sample and reduction in order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 24;
    localparam int TotalRandom = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // sample_in[23:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // sample_out[23:0], reduction_db[37:24], zero
    logic        i_cfg_we = 1'b0;
    logic [deq_pkg::CfgIdxBits-1:0]  i_cfg_idx = '0;
    logic [deq_pkg::CfgDataBits-1:0] i_cfg_data = '0;

    dynamic_eq_band uut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct {
        logic signed [23:0] sample;
        logic        [13:0] reduction;
    } t_band_result;

    // predictor state and register copy
    deq_pkg::t_cfg band_cfg;
    longint      filt_s1, filt_s2;
    longint      env_lvl, gain_red;

    logic [23:0]  pending_samples[$];
    t_band_result expected_results[$];
    int           mismatches = 0;
    int           hold_cycles = 0;
    bit           pause_send = 1'b0;
    bit           in_taken = 1'b0;

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint level_of_envelope(longint env);
        int     top;
        longint m, frac, l, db;
        if (env == 0) return -25600;
        top = 0;
        for (int i = 0; i < 40; i++) if (env[i]) top = i;
        m = (top >= 15) ? (env >> (top - 15)) : (env << (15 - top));
        frac = 0;
        for (int i = 0; i < 10; i++) begin
            m = (m * m) >> 15;
            frac = frac << 1;
            if (m >= 65536) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l = (longint'(top) - (SB - 1)) * 1024 + frac;
        db = asr(l * 24660 + 8192, 14);
        return db < -25600 ? -25600 : db;
    endfunction

    function automatic longint rnd16(longint v);
        return (v + 32768) >> 16;
    endfunction

    function automatic longint band_removal(longint gr);
        longint e, n, f, p, g;
        e = (gr * 10885 + 128) >> 8;
        n = e >> 16;
        f = e & 65535;
        p = 630;
        p = 3638 - rnd16(p * f);
        p = 15744 - rnd16(p * f);
        p = 45426 - rnd16(p * f);
        g = 65536 - rnd16(p * f);
        g = (n > 16) ? 0 : (g >> n);
        return 65536 - g;
    endfunction

    function automatic void reset_band_model();
        band_cfg = '{bp_b0: 0, bp_a1: 0, bp_a2: 0, env_attack: 65081,
                     env_release: 65520, threshold_db: -9216,
                     slope_scaled: 9557, depth_scaled: 768};
        filt_s1 = 0; filt_s2 = 0; env_lvl = 0; gain_red = 0;
    endfunction

    function automatic t_band_result compress_band(logic [23:0] raw);
        localparam longint Hi = 8388607, Lo = -8388608;
        localparam longint S48Hi = 64'sh7FFF_FFFF_FFFF, S48Lo = -S48Hi - 1;
        longint x, b0, a1, a2, y, d, c, lvl, over, comp, target, g, o;
        t_band_result r;
        x  = longint'($signed(raw));
        b0 = longint'(band_cfg.bp_b0);
        a1 = longint'(band_cfg.bp_a1);
        a2 = longint'(band_cfg.bp_a2);
        y = clip(asr(b0 * x + filt_s1 + (64'sd1 << 19), 20), Lo, Hi);
        filt_s1 = clip(-a1 * y + filt_s2, S48Lo, S48Hi);
        filt_s2 = clip(-b0 * x - a2 * y, S48Lo, S48Hi);
        d = y < 0 ? -y : y;
        if (d > Hi) d = Hi;
        c = (d > env_lvl) ? longint'(band_cfg.env_attack) : longint'(band_cfg.env_release);
        env_lvl = d + asr(c * (env_lvl - d) + 32768, 16);
        lvl = level_of_envelope(env_lvl);
        over = lvl - longint'(band_cfg.threshold_db);
        if (over < 0) over = 0;
        comp = (over * longint'(band_cfg.slope_scaled) + 8192) >> 14;
        target = comp < longint'(band_cfg.depth_scaled) ? comp : longint'(band_cfg.depth_scaled);
        g = (target > gain_red) ? 65341 : 65525;
        gain_red = target + asr(g * (gain_red - target) + 32768, 16);
        o = clip(x - asr(y * band_removal(gain_red) + 32768, 16), Lo, Hi);
        r.sample = o[23:0];
        r.reduction = gain_red[13:0];
        return r;
    endfunction

    // append one item to the send queue
    function automatic void queue_sample(logic [23:0] s);
        pending_samples = {pending_samples, s};
    endfunction

    // register write with the model kept in step; block must be idle
    task automatic write_reg(logic [deq_pkg::CfgIdxBits-1:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            deq_pkg::REG_BP_B0:     band_cfg.bp_b0 = val;
            deq_pkg::REG_BP_A1:     band_cfg.bp_a1 = val;
            deq_pkg::REG_BP_A2:     band_cfg.bp_a2 = val;
            deq_pkg::REG_ENV_ATK:   band_cfg.env_attack = val[15:0];
            deq_pkg::REG_ENV_REL:   band_cfg.env_release = val[15:0];
            deq_pkg::REG_THRESHOLD: band_cfg.threshold_db = val[15:0];
            deq_pkg::REG_SLOPE:     band_cfg.slope_scaled = val[14:0];
            deq_pkg::REG_DEPTH:     band_cfg.depth_scaled = val[13:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(2047, 0) - 1024);
            default: return 24'($urandom);
        endcase
    endfunction

    // sender: offer the head of the queue with random gaps
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // hold the item
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0 && !pause_send) begin
            in_taken = 1'b0;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_samples.pop_front();
            send_gap <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5)
                      : ($urandom_range(1, 0) ? 0 : $urandom_range(3, 1));
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // predict on each accepted item and mark it taken for the sender
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results = {expected_results, compress_band(s_axis_tdata)};
            in_taken = 1'b1;
        end
    end

    // receiver: random stalls plus a forced long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(7, 0) == 0) ? 1'b0 : 1'b1;
        end
    end

    // check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_band_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[23:0] !== want.sample ||
                    m_axis_tdata[37:24] !== want.reduction) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sample exp %h got %h, reduction exp %0d got %0d",
                                 want.sample, m_axis_tdata[23:0],
                                 want.reduction, m_axis_tdata[37:24]);
                end
            end
        end
    end

    // stimulus phases
    initial begin
        reset_band_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults give no band, then a resonant band at extremes
        for (int i = 0; i < 4; i++) queue_sample(rand_sample(i));
        wait_drained();
        write_reg(deq_pkg::REG_BP_B0, 24'h100000);
        write_reg(deq_pkg::REG_BP_A1, 24'hE00000);
        write_reg(deq_pkg::REG_BP_A2, 24'h0F0000);
        write_reg(deq_pkg::REG_THRESHOLD, 24'h000000);
        write_reg(deq_pkg::REG_SLOPE, 24'h007FFF);
        write_reg(deq_pkg::REG_DEPTH, 24'h003FFF);
        write_reg(deq_pkg::REG_ENV_ATK, 24'h000000);
        write_reg(deq_pkg::REG_ENV_REL, 24'h00FFFF);
        for (int i = 0; i < 8; i++) queue_sample(rand_sample(i & 1));
        for (int i = 0; i < 6; i++) queue_sample(rand_sample(3));
        wait_drained();
        // extreme coefficients to force filter saturation
        write_reg(deq_pkg::REG_BP_B0, 24'h7FFFFF);
        write_reg(deq_pkg::REG_BP_A1, 24'h800000);
        write_reg(deq_pkg::REG_BP_A2, 24'h7FFFFF);
        write_reg(deq_pkg::REG_THRESHOLD, 24'h009C00);
        write_reg(deq_pkg::REG_DEPTH, 24'h000000);
        write_reg(deq_pkg::REG_DEPTH, 24'h000000);
        for (int i = 0; i < 6; i++) queue_sample(rand_sample(i % 4));
        wait_drained();

        // random phases with fresh settings each time
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(deq_pkg::REG_BP_B0,
                      24'($urandom_range(1, 0) ? $urandom : $urandom_range(300000, 0)));
            write_reg(deq_pkg::REG_BP_A1, (ph % 3 == 0) ? 24'($urandom)
                      : 24'(24'hE00000 + $urandom_range(4000, 0)));
            write_reg(deq_pkg::REG_BP_A2, (ph % 3 == 0) ? 24'($urandom)
                      : 24'(24'h0F0000 + $urandom_range(4000, 0)));
            write_reg(deq_pkg::REG_ENV_ATK,
                      (ph == 1) ? 24'h00FFFF : 24'($urandom_range(65535, 0)));
            write_reg(deq_pkg::REG_ENV_REL,
                      (ph == 2) ? 24'h000000 : 24'($urandom_range(65535, 0)));
            write_reg(deq_pkg::REG_THRESHOLD,
                      (ph == 3) ? 24'h00FFFF : 24'(-$urandom_range(25600, 0)));
            write_reg(deq_pkg::REG_SLOPE, 24'($urandom_range(32767, 0)));
            write_reg(deq_pkg::REG_DEPTH,
                      (ph == 4) ? 24'h003FFF : 24'($urandom_range(12800, 0)));
            for (int i = 0; i < TotalRandom / 8; i++)
                queue_sample(rand_sample($urandom_range(6, 0) < 2 ?
                                         $urandom_range(2, 0) : 3));
            if (ph == 2) hold_cycles = 600;
            if (ph == 5) begin
                while (pending_samples.size() > 100) @(posedge i_clk);
                pause_send = 1'b1;
                while (expected_results.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                pause_send = 1'b0;
            end
            wait_drained();
        end
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
